// ===== rtl/spf_pkg.sv =====
package spf_pkg;

  localparam int unsigned DATA_W         = 16;
  localparam int unsigned MAX_DEPTH      = 65536;
  localparam int unsigned TABLE_SIZE_DEF = 65536;
  localparam int unsigned CNT_W          = 17;
  localparam int unsigned ROOT_W         = 9;
  localparam int unsigned DIV_CNT_W      = 4;

  localparam logic [DATA_W-1:0] FIRST_PRIME = 16'd2;
  localparam logic [DATA_W-1:0] UNIT_VALUE  = 16'd1;
  localparam logic [ROOT_W-1:0] FIRST_ROOT  = 9'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_SI_RD,
    S_SI_CHK,
    S_SJ_RD,
    S_SJ_CHK,
    S_IDLE,
    S_F_RD,
    S_F_LOAD,
    S_DIV
  } state_e;

endpackage

// ===== rtl/smallest_prime_factor_factorizer.sv =====
// After reset, an init sweep writes each entry with its own index, then the sieve marks the
// multiples of each prime from its square up; busy stays high until the table is built.
// Per item: each prime factor takes a table read, a load and a 16-step divider; result strobe
// in the cycle after each division; a new item is accepted only once busy is low again.
// Values below 2 or out of table range: one result the cycle after accept, no busy time.
// Results cannot be stalled by the receiver; reset restarts the table build.
module smallest_prime_factor_factorizer #(
  parameter int unsigned TABLE_SIZE = spf_pkg::TABLE_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [spf_pkg::DATA_W-1:0]  value_i,
  output logic                        valid_o,
  output logic [spf_pkg::DATA_W-1:0]  factor_o,
  output logic                        last_o,
  output logic                        no_factor_o
);
  import spf_pkg::*;

  localparam int unsigned DEPTH = (TABLE_SIZE < MAX_DEPTH) ? TABLE_SIZE : MAX_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(DEPTH - 1);

  logic [DATA_W-1:0] spf_mem [DEPTH];

  state_e state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ROOT_W-1:0]    i_q, i_d;
  logic [CNT_W-1:0]     j_q, j_d;
  logic [DATA_W-1:0]    rest_q, rest_d;
  logic [DATA_W-1:0]    f_q, f_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  logic                 valid_q, valid_d;
  logic [DATA_W-1:0]    factor_q, factor_d;
  logic                 last_q, last_d;
  logic                 none_q, none_d;

  logic [DATA_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  logic [2*ROOT_W-1:0] sq;
  logic [DATA_W:0]     shifted;
  logic                ge;
  logic [DATA_W-1:0]   quo_next;
  logic                bad_value;

  assign sq        = i_q * i_q;
  assign shifted   = {rem_q, quo_q[DATA_W-1]};
  assign ge        = shifted >= {1'b0, f_q};
  assign quo_next  = {quo_q[DATA_W-2:0], ge};
  assign bad_value = (value_i < FIRST_PRIME) || ({1'b0, value_i} >= DEPTH_C);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      spf_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= spf_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      i_q     <= FIRST_ROOT;
      j_q     <= '0;
      dcnt_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      dcnt_q  <= dcnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    f_q      <= f_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    factor_q <= factor_d;
    last_q   <= last_d;
    none_q   <= none_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    dcnt_d   = dcnt_q;
    rest_d   = rest_q;
    f_d      = f_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    valid_d  = 1'b0;
    factor_d = factor_q;
    last_d   = last_q;
    none_d   = none_q;
    rd_addr  = rest_q[AW-1:0];
    wr_addr  = cnt_q[AW-1:0];
    wr_data  = DATA_W'(cnt_q);
    wr_en    = 1'b0;

    case (state_q)
      S_INIT: begin
        wr_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_C) begin
          i_d     = FIRST_ROOT;
          state_d = S_SI_RD;
        end
      end
      S_SI_RD: begin
        rd_addr = AW'(i_q);
        if (sq >= {{(2*ROOT_W-CNT_W){1'b0}}, DEPTH_C}) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SI_CHK;
        end
      end
      S_SI_CHK: begin
        if (rd_data_q == DATA_W'(i_q)) begin
          j_d     = CNT_W'(sq);
          state_d = S_SJ_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SI_RD;
        end
      end
      S_SJ_RD: begin
        rd_addr = j_q[AW-1:0];
        if (j_q >= DEPTH_C) begin
          i_d     = i_q + 1'b1;
          state_d = S_SI_RD;
        end else begin
          state_d = S_SJ_CHK;
        end
      end
      S_SJ_CHK: begin
        wr_addr = j_q[AW-1:0];
        wr_data = DATA_W'(i_q);
        wr_en   = (rd_data_q == j_q[DATA_W-1:0]);
        j_d     = j_q + CNT_W'(i_q);
        state_d = S_SJ_RD;
      end
      S_IDLE: begin
        if (start) begin
          if (bad_value) begin
            valid_d  = 1'b1;
            factor_d = '0;
            last_d   = 1'b1;
            none_d   = 1'b1;
          end else begin
            rest_d  = value_i;
            state_d = S_F_RD;
          end
        end
      end
      S_F_RD: begin
        rd_addr = rest_q[AW-1:0];
        state_d = S_F_LOAD;
      end
      S_F_LOAD: begin
        f_d     = (rd_data_q < FIRST_PRIME) ? rest_q : rd_data_q;
        rem_d   = '0;
        quo_d   = rest_q;
        dcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d  = ge ? DATA_W'(shifted - {1'b0, f_q}) : shifted[DATA_W-1:0];
        quo_d  = quo_next;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == {DIV_CNT_W{1'b1}}) begin
          valid_d  = 1'b1;
          factor_d = f_q;
          last_d   = (quo_next == UNIT_VALUE);
          none_d   = 1'b0;
          rest_d   = quo_next;
          state_d  = (quo_next == UNIT_VALUE) ? S_IDLE : S_F_RD;
        end
      end
      default: begin
        state_d = S_INIT;
        cnt_d   = '0;
      end
    endcase
  end

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign factor_o    = factor_q;
  assign last_o      = last_q;
  assign no_factor_o = none_q;

endmodule
